// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define MWMA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// same-cycle implication
`define MWMA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

// ----- hw/rtl/mwma_pkg.sv -----
// ----------------------------------------------------------------------------
// mwma_pkg
// shared constants and window table for the multi-window moving average
// ----------------------------------------------------------------------------
package mwma_pkg;

	localparam int unsigned FIELD_BITS     = 32;
	localparam int unsigned PRICE_BITS_DEF = 32;
	localparam int unsigned NUM_WINDOWS    = 6;
	localparam int unsigned LINE_DEPTH     = 200;
	localparam int unsigned COUNT_BITS     = $clog2(LINE_DEPTH + 1);
	localparam int unsigned SUM_EXTRA      = $clog2(LINE_DEPTH);
	localparam int unsigned DIV_STAGES     = 2;
	localparam int unsigned DIV_CHUNK_BITS = 16;

	typedef logic [NUM_WINDOWS-1:0] win_mask_t;

	function automatic int unsigned win_len(input int unsigned idx);
		int unsigned len;
		case (idx)
			0: len = 5;
			1: len = 10;
			2: len = 20;
			3: len = 50;
			4: len = 100;
			5: len = 200;
			default: len = LINE_DEPTH;
		endcase
		return len;
	endfunction

endpackage

// ----- hw/rtl/mwma_history.sv -----
// ----------------------------------------------------------------------------
// mwma_history
// sample delay line with one fixed tap per window length
// ----------------------------------------------------------------------------
module mwma_history #(
	parameter int unsigned PRICE_BITS = mwma_pkg::PRICE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  shift_en,
	input  logic [PRICE_BITS-1:0] din,
	output logic [PRICE_BITS-1:0] taps [mwma_pkg::NUM_WINDOWS]
);
	import mwma_pkg::*;

	logic [PRICE_BITS-1:0] line_q [LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (shift_en) begin
			line_q[0] <= din;
			for (int i = 1; i < LINE_DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	for (genvar w = 0; w < NUM_WINDOWS; w++) begin : g_tap
		assign taps[w] = line_q[win_len(w) - 1];
	end

endmodule

// ----- hw/rtl/mwma_accum.sv -----
// ----------------------------------------------------------------------------
// mwma_accum
// running window sums and sample count, registers rounded dividends
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mwma_accum #(
	parameter int unsigned PRICE_BITS = mwma_pkg::PRICE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic                  new_series,
	input  logic [PRICE_BITS-1:0] price,
	input  logic [PRICE_BITS-1:0] taps [mwma_pkg::NUM_WINDOWS],
	output logic [PRICE_BITS+mwma_pkg::SUM_EXTRA-1:0] y_s2 [mwma_pkg::NUM_WINDOWS],
	output mwma_pkg::win_mask_t   mask_s2
);
	import mwma_pkg::*;

	localparam int unsigned SUM_BITS = PRICE_BITS + SUM_EXTRA;

	logic [SUM_BITS-1:0]   sum_q [NUM_WINDOWS];
	logic [SUM_BITS-1:0]   sum_d [NUM_WINDOWS];
	logic [SUM_BITS-1:0]   y_d   [NUM_WINDOWS];
	logic [COUNT_BITS-1:0] seen_q;
	logic [COUNT_BITS-1:0] seen_base;
	logic [COUNT_BITS-1:0] seen_d;
	win_mask_t             mask_d;

	assign seen_base = new_series ? '0 : seen_q;
	assign seen_d    = (seen_base < COUNT_BITS'(LINE_DEPTH)) ?
		seen_base + COUNT_BITS'(1) : seen_base;

	for (genvar w = 0; w < NUM_WINDOWS; w++) begin : g_win
		localparam int unsigned LEN = win_len(w);
		logic [SUM_BITS-1:0] base;
		logic [SUM_BITS-1:0] sub;

		// oldest sample leaves once the window is full
		assign base     = new_series ? '0 : sum_q[w];
		assign sub      = (!new_series && (seen_q >= COUNT_BITS'(LEN))) ?
			SUM_BITS'(taps[w]) : '0;
		assign sum_d[w] = base - sub + SUM_BITS'(price);
		assign mask_d[w] = seen_d >= COUNT_BITS'(LEN);
		// half the window length added for round to nearest
		assign y_d[w]   = mask_d[w] ? sum_d[w] + SUM_BITS'(LEN / 2) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int w = 0; w < NUM_WINDOWS; w++) begin
				sum_q[w] <= '0;
			end
		end else if (fire) begin
			seen_q <= seen_d;
			sum_q  <= sum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			y_s2    <= y_d;
			mask_s2 <= mask_d;
		end
	end

	`MWMA_ASSERT(a_seen_sat, seen_q <= COUNT_BITS'(LINE_DEPTH), "sample count past line depth")
	`MWMA_ASSERT(a_new_mask, fire && new_series |=> mask_s2 == '0, "window full on new series")

endmodule

// ----- hw/rtl/mwma_divider.sv -----
// ----------------------------------------------------------------------------
// mwma_divider
// division by a constant through reciprocal multiplication, two stages
// ----------------------------------------------------------------------------
module mwma_divider #(
	parameter int unsigned WIDTH   = 40,
	parameter int unsigned DIVISOR = 5
) (
	input  logic                            clk,
	input  logic [mwma_pkg::DIV_STAGES-1:0] en,
	input  logic [WIDTH-1:0]                dividend,
	output logic [WIDTH-1:0]                quotient
);
	import mwma_pkg::*;

	localparam int unsigned SH  = $clog2(DIVISOR);
	localparam int unsigned MW  = WIDTH + 1;
	localparam int unsigned NC  = (WIDTH + DIV_CHUNK_BITS - 1) / DIV_CHUNK_BITS;
	localparam int unsigned XW  = NC * DIV_CHUNK_BITS;
	localparam int unsigned PPW = DIV_CHUNK_BITS + MW;
	localparam int unsigned PRW = 2 * WIDTH + SH;

	function automatic logic [MW-1:0] calc_magic();
		logic [127:0] num;
		logic [127:0] q;
		num = 128'd1 << (WIDTH + SH);
		q   = (num + 128'(DIVISOR - 1)) / 128'(DIVISOR);
		return q[MW-1:0];
	endfunction

	// rounded-up reciprocal, exact floor for any dividend of WIDTH bits
	localparam logic [MW-1:0] MAGIC = calc_magic();

	logic [XW-1:0]    x_pad;
	logic [PPW-1:0]   part_q [NC];
	logic [PRW-1:0]   prod;
	logic [WIDTH-1:0] quot_q;

	assign x_pad = XW'(dividend);

	// one partial product per dividend chunk
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int c = 0; c < NC; c++) begin
				part_q[c] <= PPW'(x_pad[c*DIV_CHUNK_BITS +: DIV_CHUNK_BITS]) * PPW'(MAGIC);
			end
		end
	end

	always_comb begin
		prod = '0;
		for (int c = 0; c < NC; c++) begin
			prod = prod + (PRW'(part_q[c]) << (c * DIV_CHUNK_BITS));
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			quot_q <= prod[WIDTH+SH +: WIDTH];
		end
	end

	assign quotient = quot_q;

endmodule

// ----- hw/rtl/multi_window_moving_average.sv -----
// ----------------------------------------------------------------------------
// multi_window_moving_average
// simple moving averages over 5, 10, 20, 50, 100 and 200 samples
//
//   channel   handshake                    word
//   sample    sample_valid / sample_ready  price, new_series
//   result    result_valid / result_ready  avg_5 .. avg_200, valid_mask
//
// one sample a cycle unless result_ready holds a full pipeline; a result word
// goes through the input register, window sums, then two reciprocal multiply
// stages. reset clears sums, sample count and stage valids; the delay line is not
// cleared, a tap is only used once the current series has filled it
// a full stage holds while the one after it cannot take its word; the input
// is taken whenever some stage ahead has room
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_window_moving_average #(
	parameter int unsigned PRICE_BITS = mwma_pkg::PRICE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  logic [mwma_pkg::FIELD_BITS-1:0] price,
	input  logic                            new_series,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [mwma_pkg::FIELD_BITS-1:0] avg_5,
	output logic [mwma_pkg::FIELD_BITS-1:0] avg_10,
	output logic [mwma_pkg::FIELD_BITS-1:0] avg_20,
	output logic [mwma_pkg::FIELD_BITS-1:0] avg_50,
	output logic [mwma_pkg::FIELD_BITS-1:0] avg_100,
	output logic [mwma_pkg::FIELD_BITS-1:0] avg_200,
	output logic [mwma_pkg::NUM_WINDOWS-1:0] valid_mask
);
	import mwma_pkg::*;

	localparam int unsigned SUM_BITS   = PRICE_BITS + SUM_EXTRA;
	localparam int unsigned NUM_STAGES = DIV_STAGES + 2;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] rdy;
	logic                  fire;
	logic [PRICE_BITS-1:0] price_s1;
	logic                  new_series_s1;
	logic [PRICE_BITS-1:0] taps [NUM_WINDOWS];
	logic [SUM_BITS-1:0]   y_s2 [NUM_WINDOWS];
	win_mask_t             mask_s2;
	logic [SUM_BITS-1:0]   quot [NUM_WINDOWS];
	win_mask_t             mask_pipe_q [DIV_STAGES];

	always_comb begin
		rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || result_ready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign sample_ready = rdy[0];
	assign result_valid = vld_q[NUM_STAGES-1];
	assign fire         = vld_q[0] && rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= sample_valid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			price_s1      <= PRICE_BITS'(price);
			new_series_s1 <= new_series;
		end
	end

	mwma_history #(
		.PRICE_BITS(PRICE_BITS)
	) u_history (
		.clk     (clk),
		.shift_en(fire),
		.din     (price_s1),
		.taps    (taps)
	);

	mwma_accum #(
		.PRICE_BITS(PRICE_BITS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.new_series(new_series_s1),
		.price     (price_s1),
		.taps      (taps),
		.y_s2      (y_s2),
		.mask_s2   (mask_s2)
	);

	for (genvar w = 0; w < NUM_WINDOWS; w++) begin : g_div
		mwma_divider #(
			.WIDTH  (SUM_BITS),
			.DIVISOR(win_len(w))
		) u_divider (
			.clk     (clk),
			.en      (rdy[NUM_STAGES-1:2]),
			.dividend(y_s2[w]),
			.quotient(quot[w])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			mask_pipe_q[0] <= mask_s2;
		end
		for (int s = 1; s < DIV_STAGES; s++) begin
			if (rdy[s+2]) begin
				mask_pipe_q[s] <= mask_pipe_q[s-1];
			end
		end
	end

	assign avg_5      = FIELD_BITS'(quot[0]);
	assign avg_10     = FIELD_BITS'(quot[1]);
	assign avg_20     = FIELD_BITS'(quot[2]);
	assign avg_50     = FIELD_BITS'(quot[3]);
	assign avg_100    = FIELD_BITS'(quot[4]);
	assign avg_200    = FIELD_BITS'(quot[5]);
	assign valid_mask = mask_pipe_q[DIV_STAGES-1];

	`MWMA_ASSERT_IMP(a_mask_contig, result_valid, ((valid_mask + NUM_WINDOWS'(1)) & valid_mask) == '0, "longer window full before shorter")
	`MWMA_ASSERT_IMP(a_avg_zero, result_valid && !valid_mask[NUM_WINDOWS-1], avg_200 == '0, "average of unfilled window not zero")

endmodule
